### sv/jsos_pkg.sv
`default_nettype none

package jsos_pkg;

    // default brace depth counter width
    localparam int DEPTH_BITS_DEF = 16;

    // depth of the queue between classifier and executor
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // characters of interest
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_VT       = 8'h0B;
    localparam logic [7:0] CH_FF       = 8'h0C;
    localparam logic [7:0] CH_CR       = 8'h0D;

    // error codes on the result
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_BRACE = 2'd1;
    localparam logic [1:0] ERR_END   = 2'd2;
    localparam logic [1:0] ERR_DEPTH = 2'd3;

    // byte class found by the front end
    typedef enum logic [3:0] {
        CLS_OTHER,
        CLS_SPACE,
        CLS_TERM,
        CLS_COMMA,
        CLS_LBRACE,
        CLS_RBRACE,
        CLS_QUOTE,
        CLS_BSLASH,
        CLS_END
    } t_cls;

    // parser phase
    typedef enum logic [2:0] {
        PH_EXPECT    = 3'd0,
        PH_AFTER     = 3'd1,
        PH_OBJECT    = 3'd2,
        PH_STOP      = 3'd3,
        PH_ERR_BRACE = 3'd4,
        PH_ERR_END   = 3'd5,
        PH_ERR_DEPTH = 3'd6
    } t_phase;

    // one queued word
    typedef struct packed {
        logic [7:0] data;
        t_cls       cls;
    } t_qword;

    // queue status
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

`default_nettype wire

### sv/json_object_stream_splitter_unit.sv
`default_nettype none

// channel  | direction | handshake                 | payload
// ---------+-----------+---------------------------+------------------------------------
// in       | input     | i_in_valid / o_in_stall   | i_data_byte, i_end_marker
// out      | output    | o_out_valid / i_out_stall | o_byte_out, o_in_object, o_object_first,
//          |           |                           | o_object_last, o_stopped, o_error_code
// cfg      | input     | i_cfg_valid / o_cfg_ready | i_cfg_bracket_mode
//
// one word per clock in and out while neither side stalls; with the queue empty a word taken
// is written into the queue and then into the output register (one queue stage, one out reg)
// the rate is set by the parser state update in the back end
// reset is synchronous, active low; it clears the queue, the parser and bracket mode
// o_in_stall rises only when the four-entry queue is full; cfg is always ready

module json_object_stream_splitter_unit #(
    parameter int DEPTH_BITS = jsos_pkg::DEPTH_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_bracket_mode,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_marker,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_byte_out,
    output logic             o_in_object,
    output logic             o_object_first,
    output logic             o_object_last,
    output logic             o_stopped,
    output logic [1:0]       o_error_code
);

    jsos_pkg::t_qword in_word;
    jsos_pkg::t_qword head_word;
    jsos_pkg::t_qstat q_stat;
    logic             push;
    logic             pop;

    // classifier and configuration
    jsos_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_bracket_mode (i_cfg_bracket_mode),
        .i_data_byte        (i_data_byte),
        .i_end_marker       (i_end_marker),
        .o_word             (in_word)
    );

    assign o_in_stall = q_stat.full;
    assign push       = i_in_valid && !q_stat.full;

    // decoupling queue
    jsos_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (in_word),
        .i_pop   (pop),
        .o_word  (head_word),
        .o_stat  (q_stat)
    );

    // parser and output register
    jsos_back #(
        .DEPTH_BITS (DEPTH_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_word         (head_word),
        .i_empty        (q_stat.empty),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_byte_out     (o_byte_out),
        .o_in_object    (o_in_object),
        .o_object_first (o_object_first),
        .o_object_last  (o_object_last),
        .o_stopped      (o_stopped),
        .o_error_code   (o_error_code)
    );

    // queue cannot be full and empty at once
    a_queue_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue full and empty together");

    // nothing is popped from an empty queue
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.empty |-> !pop)
        else $error("pop from empty queue");

    // an opening brace of an object is never a stopped word
    a_first_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_object_first) |-> (o_in_object && !o_stopped && !o_object_last))
        else $error("object start flagged on a stopped or closing word");

    // any error means stopped
    a_err_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_error_code != jsos_pkg::ERR_NONE) |-> o_stopped)
        else $error("error reported without stop");

endmodule

`default_nettype wire

### sv/jsos_front.sv
`default_nettype none

module jsos_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic              i_cfg_bracket_mode,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_end_marker,
    output jsos_pkg::t_qword       o_word
);

    logic       r_bracket_mode;
    logic [7:0] term_ch;

    // configuration register, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bracket_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            r_bracket_mode <= i_cfg_bracket_mode;
        end
    end

    assign term_ch = r_bracket_mode ? jsos_pkg::CH_RBRACKET : jsos_pkg::CH_SEMI;

    // classify the incoming byte
    always_comb begin
        o_word.data = i_end_marker ? 8'h00 : i_data_byte;
        if (i_end_marker) begin
            o_word.cls = jsos_pkg::CLS_END;
        end else if (i_data_byte inside {jsos_pkg::CH_SPACE, jsos_pkg::CH_TAB,
                                         jsos_pkg::CH_LF, jsos_pkg::CH_VT,
                                         jsos_pkg::CH_FF, jsos_pkg::CH_CR}) begin
            o_word.cls = jsos_pkg::CLS_SPACE;
        end else if (i_data_byte == term_ch) begin
            o_word.cls = jsos_pkg::CLS_TERM;
        end else begin
            case (i_data_byte)
                jsos_pkg::CH_COMMA:  o_word.cls = jsos_pkg::CLS_COMMA;
                jsos_pkg::CH_LBRACE: o_word.cls = jsos_pkg::CLS_LBRACE;
                jsos_pkg::CH_RBRACE: o_word.cls = jsos_pkg::CLS_RBRACE;
                jsos_pkg::CH_QUOTE:  o_word.cls = jsos_pkg::CLS_QUOTE;
                jsos_pkg::CH_BSLASH: o_word.cls = jsos_pkg::CLS_BSLASH;
                default:             o_word.cls = jsos_pkg::CLS_OTHER;
            endcase
        end
    end

endmodule

`default_nettype wire

### sv/jsos_queue.sv
`default_nettype none

module jsos_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire jsos_pkg::t_qword  i_word,
    input  wire logic              i_pop,
    output jsos_pkg::t_qword       o_word,
    output jsos_pkg::t_qstat       o_stat
);

    jsos_pkg::t_qword                   r_mem [jsos_pkg::Q_DEPTH];
    logic [jsos_pkg::Q_PTR_W-1:0]       r_wr_ptr;
    logic [jsos_pkg::Q_PTR_W-1:0]       r_rd_ptr;
    logic [jsos_pkg::Q_CNT_W-1:0]       r_count;
    logic [jsos_pkg::Q_CNT_W-1:0]       n_count;

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + jsos_pkg::Q_CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - jsos_pkg::Q_CNT_W'(1);
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == jsos_pkg::Q_PTR_W'(jsos_pkg::Q_DEPTH - 1)) ?
                            '0 : r_wr_ptr + jsos_pkg::Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == jsos_pkg::Q_PTR_W'(jsos_pkg::Q_DEPTH - 1)) ?
                            '0 : r_rd_ptr + jsos_pkg::Q_PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    assign o_word       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == jsos_pkg::Q_CNT_W'(jsos_pkg::Q_DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

`default_nettype wire

### sv/jsos_back.sv
`default_nettype none

module jsos_back #(
    parameter int DEPTH_BITS = jsos_pkg::DEPTH_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire jsos_pkg::t_qword  i_word,
    input  wire logic              i_empty,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [7:0]             o_byte_out,
    output logic                   o_in_object,
    output logic                   o_object_first,
    output logic                   o_object_last,
    output logic                   o_stopped,
    output logic [1:0]             o_error_code
);

    jsos_pkg::t_phase        r_phase;
    jsos_pkg::t_phase        n_phase;
    logic [DEPTH_BITS-1:0]   r_depth;
    logic [DEPTH_BITS-1:0]   n_depth;
    logic                    r_in_str;
    logic                    n_in_str;
    logic                    r_esc;
    logic                    n_esc;
    logic                    r_out_valid;
    logic                    take;

    // result fields for the word at the head
    logic                    inobj;
    logic                    first;
    logic                    last;
    logic                    stop;
    logic [1:0]              err;

    logic [7:0]              r_byte_out;
    logic                    r_in_object;
    logic                    r_object_first;
    logic                    r_object_last;
    logic                    r_stopped;
    logic [1:0]              r_error_code;

    // output register free or being emptied this cycle
    assign take  = !r_out_valid || !i_out_stall;
    assign o_pop = take && !i_empty;

    // next state
    always_comb begin
        n_phase  = r_phase;
        n_depth  = r_depth;
        n_in_str = r_in_str;
        n_esc    = r_esc;
        case (r_phase)
            jsos_pkg::PH_EXPECT, jsos_pkg::PH_AFTER: begin
                case (i_word.cls)
                    jsos_pkg::CLS_END, jsos_pkg::CLS_TERM: n_phase = jsos_pkg::PH_STOP;
                    jsos_pkg::CLS_SPACE: n_phase = r_phase;
                    jsos_pkg::CLS_COMMA: begin
                        n_phase = (r_phase == jsos_pkg::PH_AFTER) ?
                                  jsos_pkg::PH_EXPECT : jsos_pkg::PH_ERR_BRACE;
                    end
                    jsos_pkg::CLS_LBRACE: begin
                        n_phase  = jsos_pkg::PH_OBJECT;
                        n_depth  = DEPTH_BITS'(1);
                        n_in_str = 1'b0;
                        n_esc    = 1'b0;
                    end
                    default: n_phase = jsos_pkg::PH_ERR_BRACE;
                endcase
            end
            jsos_pkg::PH_OBJECT: begin
                if (i_word.cls == jsos_pkg::CLS_END) begin
                    n_phase = jsos_pkg::PH_ERR_END;
                end else if (r_esc) begin
                    n_esc = 1'b0;
                end else if (i_word.cls == jsos_pkg::CLS_BSLASH) begin
                    n_esc = 1'b1;
                end else if (r_in_str) begin
                    if (i_word.cls == jsos_pkg::CLS_QUOTE) begin
                        n_in_str = 1'b0;
                    end
                end else begin
                    case (i_word.cls)
                        jsos_pkg::CLS_QUOTE: n_in_str = 1'b1;
                        jsos_pkg::CLS_LBRACE: begin
                            if (r_depth == '1) begin
                                n_phase = jsos_pkg::PH_ERR_DEPTH;
                            end else begin
                                n_depth = r_depth + DEPTH_BITS'(1);
                            end
                        end
                        jsos_pkg::CLS_RBRACE: begin
                            if (r_depth != '0) begin
                                n_depth = r_depth - DEPTH_BITS'(1);
                            end
                            if (r_depth == '0 || r_depth == DEPTH_BITS'(1)) begin
                                n_phase = jsos_pkg::PH_AFTER;
                            end
                        end
                        default: n_phase = r_phase;
                    endcase
                end
            end
            default: n_phase = r_phase;
        endcase
    end

    // result fields
    always_comb begin
        inobj = 1'b0;
        first = 1'b0;
        last  = 1'b0;
        case (r_phase)
            jsos_pkg::PH_EXPECT, jsos_pkg::PH_AFTER: begin
                if (i_word.cls == jsos_pkg::CLS_LBRACE) begin
                    inobj = 1'b1;
                    first = 1'b1;
                end
            end
            jsos_pkg::PH_OBJECT: begin
                inobj = (i_word.cls != jsos_pkg::CLS_END);
                last  = (n_phase == jsos_pkg::PH_AFTER);
            end
            default: inobj = 1'b0;
        endcase
        stop = (n_phase >= jsos_pkg::PH_STOP);
        case (n_phase)
            jsos_pkg::PH_ERR_BRACE: err = jsos_pkg::ERR_BRACE;
            jsos_pkg::PH_ERR_END:   err = jsos_pkg::ERR_END;
            jsos_pkg::PH_ERR_DEPTH: err = jsos_pkg::ERR_DEPTH;
            default:                err = jsos_pkg::ERR_NONE;
        endcase
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= jsos_pkg::PH_EXPECT;
            r_depth  <= '0;
            r_in_str <= 1'b0;
            r_esc    <= 1'b0;
        end else if (o_pop) begin
            r_phase  <= n_phase;
            r_depth  <= n_depth;
            r_in_str <= n_in_str;
            r_esc    <= n_esc;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= !i_empty;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_byte_out     <= i_word.data;
            r_in_object    <= inobj;
            r_object_first <= first;
            r_object_last  <= last;
            r_stopped      <= stop;
            r_error_code   <= err;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_byte_out     = r_byte_out;
    assign o_in_object    = r_in_object;
    assign o_object_first = r_object_first;
    assign o_object_last  = r_object_last;
    assign o_stopped      = r_stopped;
    assign o_error_code   = r_error_code;

endmodule

`default_nettype wire

### sim/json_object_stream_splitter_unit_tb.sv
`timescale 1ns / 1ps

module json_object_stream_splitter_unit_tb;

    // small depth counter so that full nesting and overflow are cheap to reach
    localparam int DEPTH_W   = 4;
    localparam int DEPTH_TOP = (1 << DEPTH_W) - 1;
    localparam int IDLE_LIMIT = 2000;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } t_stream_word;

    typedef struct packed {
        logic [7:0] data;
        logic       in_obj;
        logic       first;
        logic       last;
        logic       stopped;
        logic [1:0] err;
    } t_split_mark;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_bm = 1'b0;
    logic in_valid = 1'b0;
    logic [7:0] in_data = 8'h00;
    logic in_fin = 1'b0;
    logic out_stall = 1'b0;

    wire       o_cfg_ready;
    wire       o_in_stall;
    wire       o_out_valid;
    wire [7:0] o_byte_out;
    wire       o_in_object;
    wire       o_object_first;
    wire       o_object_last;
    wire       o_stopped;
    wire [1:0] o_error_code;

    json_object_stream_splitter_unit #(
        .DEPTH_BITS(DEPTH_W)
    ) dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_bracket_mode(cfg_bm),
        .i_in_valid(in_valid),
        .o_in_stall(o_in_stall),
        .i_data_byte(in_data),
        .i_end_marker(in_fin),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_byte_out(o_byte_out),
        .o_in_object(o_in_object),
        .o_object_first(o_object_first),
        .o_object_last(o_object_last),
        .o_stopped(o_stopped),
        .o_error_code(o_error_code)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    t_stream_word pending_words[$];
    t_split_mark  expected_marks[$];

    // splitter state as the testbench sees it
    jsos_pkg::t_phase   ph = jsos_pkg::PH_EXPECT;
    logic [DEPTH_W-1:0] nest_depth = '0;
    logic               in_str = 1'b0;
    logic               esc = 1'b0;
    logic               brk_mode = 1'b0;

    int errors = 0;
    int n_queued = 0;
    int n_issued = 0;
    int n_taken = 0;
    int n_out = 0;
    int n_objects = 0;
    int n_cfg = 0;
    int deepest = 0;
    int tx_gap = 0;
    int stall_left = 0;
    int hold_left = 0;
    bit held_once = 0;
    int idle_cycles = 0;
    logic [31:0] cyc = '0;
    t_stream_word tx_word;
    t_split_mark want;
    t_split_mark got;

    // advance the splitter by one word and give the marks it should carry
    function automatic t_split_mark split_next(input logic [7:0] c, input logic fin);
        t_split_mark m;
        logic [7:0] term;
        m = '0;
        term = brk_mode ? jsos_pkg::CH_RBRACKET : jsos_pkg::CH_SEMI;
        case (ph)
            jsos_pkg::PH_EXPECT, jsos_pkg::PH_AFTER: begin
                if (fin) begin
                    ph = jsos_pkg::PH_STOP;
                end else if (c inside {jsos_pkg::CH_SPACE, jsos_pkg::CH_TAB, jsos_pkg::CH_LF,
                                       jsos_pkg::CH_CR, jsos_pkg::CH_FF, jsos_pkg::CH_VT}) begin
                    // whitespace between objects is dropped
                end else if (c == term) begin
                    ph = jsos_pkg::PH_STOP;
                end else if (c == jsos_pkg::CH_COMMA && ph == jsos_pkg::PH_AFTER) begin
                    ph = jsos_pkg::PH_EXPECT;
                end else if (c == jsos_pkg::CH_LBRACE) begin
                    ph = jsos_pkg::PH_OBJECT;
                    nest_depth = 1;
                    in_str = 1'b0;
                    esc = 1'b0;
                    m.in_obj = 1'b1;
                    m.first = 1'b1;
                end else begin
                    ph = jsos_pkg::PH_ERR_BRACE;
                end
            end
            jsos_pkg::PH_OBJECT: begin
                if (fin) begin
                    ph = jsos_pkg::PH_ERR_END;
                end else begin
                    m.in_obj = 1'b1;
                    if (esc) begin
                        esc = 1'b0;
                    end else if (c == jsos_pkg::CH_BSLASH) begin
                        esc = 1'b1;
                    end else if (in_str) begin
                        if (c == jsos_pkg::CH_QUOTE) in_str = 1'b0;
                    end else if (c == jsos_pkg::CH_QUOTE) begin
                        in_str = 1'b1;
                    end else if (c == jsos_pkg::CH_LBRACE) begin
                        // saturated depth stays put and stops the stream
                        if (nest_depth == '1) ph = jsos_pkg::PH_ERR_DEPTH;
                        else nest_depth = nest_depth + 1'b1;
                    end else if (c == jsos_pkg::CH_RBRACE) begin
                        if (nest_depth != 0) nest_depth = nest_depth - 1'b1;
                        if (nest_depth == 0) begin
                            m.last = 1'b1;
                            ph = jsos_pkg::PH_AFTER;
                        end
                    end
                end
            end
            default: begin
                // stopped: nothing moves
            end
        endcase
        m.stopped = (ph >= jsos_pkg::PH_STOP);
        case (ph)
            jsos_pkg::PH_ERR_BRACE: m.err = jsos_pkg::ERR_BRACE;
            jsos_pkg::PH_ERR_END:   m.err = jsos_pkg::ERR_END;
            jsos_pkg::PH_ERR_DEPTH: m.err = jsos_pkg::ERR_DEPTH;
            default:                m.err = jsos_pkg::ERR_NONE;
        endcase
        m.data = fin ? 8'h00 : c;
        return m;
    endfunction

    // cycle count for calm stretches
    always @(posedge clk) begin
        cyc <= cyc + 1;
    end

    // word driver: holds a stalled word, otherwise sends the next queued one after a gap
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                expected_marks.push_back(split_next(in_data, in_fin));
                n_taken++;
                if (nest_depth > deepest) deepest = nest_depth;
            end
            if (!(in_valid && o_in_stall)) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    in_valid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    tx_word = pending_words.pop_front();
                    n_issued++;
                    in_valid <= 1'b1;
                    in_data <= tx_word.data;
                    in_fin <= tx_word.fin;
                    if (cyc[8:7] == 2'd0 || $urandom_range(0, 99) < 70) tx_gap = 0;
                    else if ($urandom_range(0, 9) == 0) tx_gap = $urandom_range(8, 40);
                    else tx_gap = $urandom_range(1, 3);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string what, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, act_v);
            errors++;
        end
    endtask

    // result monitor and receiver stall
    always @(posedge clk) begin
        if (rst_n) begin
            if (o_out_valid && !out_stall) begin
                n_out++;
                got = {o_byte_out, o_in_object, o_object_first, o_object_last, o_stopped,
                       o_error_code};
                if (o_object_first) n_objects++;
                if (expected_marks.size() == 0) begin
                    $display("%0t: result with nothing expected, expected none, got %h",
                             $time, got);
                    errors++;
                end else begin
                    want = expected_marks.pop_front();
                    check_field("byte_out", want.data, got.data);
                    check_field("in_object", want.in_obj, got.in_obj);
                    check_field("object_first", want.first, got.first);
                    check_field("object_last", want.last, got.last);
                    check_field("stopped", want.stopped, got.stopped);
                    check_field("error_code", want.err, got.err);
                end
            end
            // one long hold-off so the input side backs up
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (!held_once && n_out >= 400) begin
                held_once = 1;
                hold_left = 300;
                out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (cyc[9:8] != 2'd2 && $urandom_range(0, 99) >= 60) begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                          : $urandom_range(0, 2);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) ||
                (cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
                    $display("== FAIL ==");
                    $finish;
                end
            end
        end
    end

    task automatic put(input logic [7:0] b);
        pending_words.push_back('{data: b, fin: 1'b0});
        n_queued++;
    endtask

    task automatic put_end();
        logic [7:0] junk;
        junk = $urandom_range(0, 255);
        pending_words.push_back('{data: junk, fin: 1'b1});
        n_queued++;
    endtask

    task automatic put_any();
        put($urandom_range(0, 255));
    endtask

    // byte with no meaning inside an object
    task automatic put_plain();
        logic [7:0] b;
        b = jsos_pkg::CH_LBRACE;
        while (b inside {jsos_pkg::CH_LBRACE, jsos_pkg::CH_RBRACE, jsos_pkg::CH_QUOTE,
                         jsos_pkg::CH_BSLASH})
            b = $urandom_range(0, 255);
        put(b);
    endtask

    task automatic put_ws();
        case ($urandom_range(0, 5))
            0: put(jsos_pkg::CH_SPACE);
            1: put(jsos_pkg::CH_TAB);
            2: put(jsos_pkg::CH_LF);
            3: put(jsos_pkg::CH_CR);
            4: put(jsos_pkg::CH_FF);
            default: put(jsos_pkg::CH_VT);
        endcase
    endtask

    // quoted string with random content and escapes
    task automatic put_string();
        logic [7:0] b;
        put(jsos_pkg::CH_QUOTE);
        repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 6) == 0) begin
                put(jsos_pkg::CH_BSLASH);
                put_any();
            end else begin
                b = jsos_pkg::CH_QUOTE;
                while (b == jsos_pkg::CH_QUOTE || b == jsos_pkg::CH_BSLASH)
                    b = $urandom_range(0, 255);
                put(b);
            end
        end
        put(jsos_pkg::CH_QUOTE);
    endtask

    // well-formed object; a deep one climbs to the top of the depth counter
    task automatic put_object(input bit deep);
        int d;
        put(jsos_pkg::CH_LBRACE);
        d = 1;
        if (deep) begin
            while (d < DEPTH_TOP) begin
                if ($urandom_range(0, 2) == 0) put_plain();
                put(jsos_pkg::CH_LBRACE);
                d++;
            end
        end
        repeat ($urandom_range(0, 24)) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    if (d < DEPTH_TOP) begin
                        put(jsos_pkg::CH_LBRACE);
                        d++;
                    end
                end
                2: begin
                    if (d > 1) begin
                        put(jsos_pkg::CH_RBRACE);
                        d--;
                    end
                end
                3, 4: put_string();
                5: begin
                    put(jsos_pkg::CH_BSLASH);
                    put_any();
                end
                default: put_plain();
            endcase
        end
        while (d > 0) begin
            put(jsos_pkg::CH_RBRACE);
            d--;
        end
    endtask

    // whitespace between objects, with at most one comma
    task automatic put_gap();
        repeat ($urandom_range(0, 3)) put_ws();
        if ($urandom_range(0, 1) == 1) begin
            put(jsos_pkg::CH_COMMA);
            repeat ($urandom_range(0, 2)) put_ws();
        end
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || n_issued != n_taken || expected_marks.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_bracket(input logic v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_bm <= v;
        @(posedge clk);
        while (!o_cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        brk_mode = v;
        n_cfg++;
    endtask

    initial begin : stimulus
        int target;
        int ending;
        logic [7:0] b;
        logic [7:0] term;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        set_bracket(1'b0);

        // directed: every whitespace kind before the first object
        put(jsos_pkg::CH_SPACE);
        put(jsos_pkg::CH_TAB);
        put(jsos_pkg::CH_LF);
        put(jsos_pkg::CH_CR);
        put(jsos_pkg::CH_FF);
        put(jsos_pkg::CH_VT);
        // braces inside a string, escaped quote inside a string
        put(jsos_pkg::CH_LBRACE);
        put(jsos_pkg::CH_QUOTE);
        put(jsos_pkg::CH_RBRACE);
        put(jsos_pkg::CH_LBRACE);
        put(jsos_pkg::CH_BSLASH);
        put(jsos_pkg::CH_QUOTE);
        put(jsos_pkg::CH_QUOTE);
        put(jsos_pkg::CH_RBRACE);
        // comma after an object, both terminators inside, escaped brace outside a string
        put(jsos_pkg::CH_COMMA);
        put(jsos_pkg::CH_SPACE);
        put(jsos_pkg::CH_LBRACE);
        put(8'hFF);
        put(jsos_pkg::CH_SEMI);
        put(jsos_pkg::CH_RBRACKET);
        put(jsos_pkg::CH_BSLASH);
        put(jsos_pkg::CH_RBRACE);
        put(jsos_pkg::CH_LBRACE);
        put(jsos_pkg::CH_RBRACE);
        put(jsos_pkg::CH_RBRACE);

        // random streams of objects under alternating terminator settings, the last one picked at random
        for (int p = 0; p < 4; p++) begin
            wait_idle();
            if (p == 3) set_bracket($urandom_range(0, 1));
            else set_bracket(p % 2 == 0);
            target = n_queued + 240;
            put_gap();
            put_object(1'b1);
            while (n_queued < target) begin
                put_gap();
                put_object(1'b0);
            end
        end

        // one way of stopping, since every stop is final
        term = brk_mode ? jsos_pkg::CH_RBRACKET : jsos_pkg::CH_SEMI;
        ending = $urandom_range(0, 5);
        case (ending)
            0: put(term);
            1: put_end();
            2: begin
                b = jsos_pkg::CH_LBRACE;
                while (b == term ||
                       b inside {jsos_pkg::CH_LBRACE, jsos_pkg::CH_COMMA, jsos_pkg::CH_SPACE,
                                 jsos_pkg::CH_TAB, jsos_pkg::CH_LF, jsos_pkg::CH_CR,
                                 jsos_pkg::CH_FF, jsos_pkg::CH_VT})
                    b = $urandom_range(0, 255);
                put(b);
            end
            3: begin
                put(jsos_pkg::CH_COMMA);
                put(jsos_pkg::CH_SPACE);
                put(jsos_pkg::CH_COMMA);
            end
            4: begin
                put(jsos_pkg::CH_LBRACE);
                put_string();
                put_end();
            end
            default: repeat (DEPTH_TOP + 1) put(jsos_pkg::CH_LBRACE);
        endcase
        // after the stop everything passes through with no object marks, only the stop and error
        repeat (4) put_any();
        put(jsos_pkg::CH_LBRACE);
        put_end();
        put_end();
        put_any();

        wait_idle();
        repeat (8) @(posedge clk);
        $display("covered %0d words in, %0d results, %0d objects, deepest nesting %0d",
                 n_taken, n_out, n_objects, deepest);
        $display("%0d config writes, stream ended by case %0d with error code %0d",
                 n_cfg, ending, want.err);
        if (errors == 0 && expected_marks.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### json_object_stream_splitter_unit.f
sv/jsos_pkg.sv
sv/jsos_front.sv
sv/jsos_queue.sv
sv/jsos_back.sv
sv/json_object_stream_splitter_unit.sv
sim/json_object_stream_splitter_unit_tb.sv
